// ===== design/dll_pkg.sv =====
// Shared widths, operation codes and table write controls of the linked list manager.
package dll_pkg;

	// Default pool geometry
	localparam int NODE_COUNT_DEF = 64;
	localparam int LIST_COUNT_DEF = 4;

	// Transaction field widths
	localparam int FUNC_W    = 3;
	localparam int LIST_ID_W = 2;
	localparam int NODE_ID_W = 6;
	localparam int COUNT_W   = 7;

	// Operation codes
	typedef logic [FUNC_W-1:0] func_t;
	localparam func_t FN_CLEAN  = 3'd0;
	localparam func_t FN_HEAD   = 3'd1;
	localparam func_t FN_TAIL   = 3'd2;
	localparam func_t FN_BEFORE = 3'd3;
	localparam func_t FN_AFTER  = 3'd4;
	localparam func_t FN_REMOVE = 3'd5;

	// Write strobes into the node table
	typedef struct packed {
		logic next_we;
		logic prev_we;
		logic link_set;
		logic link_clr;
	} node_wr_t;

endpackage

// ===== design/dll_req_if.sv =====
// Request channel: one list operation per transaction.
interface dll_req_if;
	logic                             valid;
	logic                             ready;
	logic [dll_pkg::FUNC_W-1:0]       func;
	logic [dll_pkg::LIST_ID_W-1:0]    list_id;
	logic [dll_pkg::NODE_ID_W-1:0]    node_id;
	logic [dll_pkg::NODE_ID_W-1:0]    ref_node_id;

	modport source (output valid, func, list_id, node_id, ref_node_id, input ready);
	modport sink   (input valid, func, list_id, node_id, ref_node_id, output ready);
endinterface

// ===== design/dll_rsp_if.sv =====
// Response channel: status and state of the affected list.
interface dll_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             status;
	logic [dll_pkg::COUNT_W-1:0]      list_count;
	logic [dll_pkg::NODE_ID_W-1:0]    head_node;
	logic [dll_pkg::NODE_ID_W-1:0]    tail_node;
	logic                             list_nonempty;

	modport source (output valid, status, list_count, head_node, tail_node, list_nonempty,
		input ready);
	modport sink   (input valid, status, list_count, head_node, tail_node, list_nonempty,
		output ready);
endinterface

// ===== design/dll_node_tbl.sv =====
// Node table: next/prev/owner memories plus the per-node linked flags.
module dll_node_tbl #(
	parameter int NODE_COUNT = dll_pkg::NODE_COUNT_DEF,
	parameter int LIST_COUNT = dll_pkg::LIST_COUNT_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  dll_pkg::node_wr_t                                  wr,
	// shared read port, data registered
	input  logic                                               rd_en,
	input  logic [$clog2(NODE_COUNT)-1:0]                      rd_idx,
	output logic [$clog2(NODE_COUNT + 1)-1:0]                  next_rd,
	output logic [$clog2(NODE_COUNT + 1)-1:0]                  prev_rd,
	output logic [((LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1)-1:0] owner_rd,
	// write ports
	input  logic [$clog2(NODE_COUNT)-1:0]                      next_wa,
	input  logic [$clog2(NODE_COUNT + 1)-1:0]                  next_wd,
	input  logic [$clog2(NODE_COUNT)-1:0]                      prev_wa,
	input  logic [$clog2(NODE_COUNT + 1)-1:0]                  prev_wd,
	input  logic [$clog2(NODE_COUNT)-1:0]                      link_idx,
	input  logic [((LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1)-1:0] owner_wd,
	// linked flag lookups
	input  logic [$clog2(NODE_COUNT)-1:0]                      lk_a_idx,
	input  logic [$clog2(NODE_COUNT)-1:0]                      lk_b_idx,
	output logic                                               lk_a,
	output logic                                               lk_b
);
	localparam int PW = $clog2(NODE_COUNT + 1);
	localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;

	logic [PW-1:0]         next_mem  [NODE_COUNT];
	logic [PW-1:0]         prev_mem  [NODE_COUNT];
	logic [LW-1:0]         owner_mem [NODE_COUNT];
	logic [NODE_COUNT-1:0] linked_q;

	// Memories: one write each per cycle, registered read
	always_ff @(posedge clk) begin
		if (wr.next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (wr.prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (wr.link_set) begin
			owner_mem[link_idx] <= owner_wd;
		end
		if (rd_en) begin
			next_rd  <= next_mem[rd_idx];
			prev_rd  <= prev_mem[rd_idx];
			owner_rd <= owner_mem[rd_idx];
		end
	end

	// Linked flags double as valid bits for the memories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linked_q <= '0;
		end else begin
			if (wr.link_set) begin
				linked_q[link_idx] <= 1'b1;
			end else if (wr.link_clr) begin
				linked_q[link_idx] <= 1'b0;
			end
		end
	end

	assign lk_a = linked_q[lk_a_idx];
	assign lk_b = linked_q[lk_b_idx];

endmodule

// ===== design/dll_list_tbl.sv =====
// List table: {size, head, tail} record per list, a clear valid bit reads as empty list.
module dll_list_tbl #(
	parameter int NODE_COUNT = dll_pkg::NODE_COUNT_DEF,
	parameter int LIST_COUNT = dll_pkg::LIST_COUNT_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               rd_en,
	input  logic [((LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1)-1:0] rd_addr,
	output logic [3*$clog2(NODE_COUNT + 1)-1:0]                rd_data,
	input  logic                                               wr_en,
	input  logic [((LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1)-1:0] wr_addr,
	input  logic [3*$clog2(NODE_COUNT + 1)-1:0]                wr_data
);
	localparam int PW = $clog2(NODE_COUNT + 1);
	localparam int RW = 3 * PW;
	localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);

	logic [RW-1:0]         rec_mem [LIST_COUNT];
	logic [LIST_COUNT-1:0] valid_q;
	logic [RW-1:0]         rd_raw_q;
	logic                  rd_vld_q;

	// Record memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rec_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= rec_mem[rd_addr];
		end
	end

	// Valid bits, one per list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// Never written: empty list
	assign rd_data = rd_vld_q ? rd_raw_q : {PW'(0), NIL, NIL};

endmodule

// ===== design/doubly_linked_list_manager.sv =====
// Top level: sequencer over the node and list tables with a shared +/-1 unit.
//
//  channel | dir | payload                                            | handshake
//  req     | in  | func, list_id, node_id, ref_node_id                | valid/ready
//  rsp     | out | status, list_count, head_node, tail_node, nonempty | valid/ready
//
// Steps: check, node read (before/after/remove), list read, link+link2 (insert),
// unlink+list write (remove) or walk+walk read per node, list write (clean); done.
// Failures skip to done, which idles as valid rises. Steps are dependent table accesses.
// Reset clears the linked flags and list valid bits at once; no clearing pass.
// req.ready is high only in idle; a parked response does not block the next request,
// which waits in its done step only while the previous response is still unaccepted.
module doubly_linked_list_manager #(
	parameter int NODE_COUNT = dll_pkg::NODE_COUNT_DEF,
	parameter int LIST_COUNT = dll_pkg::LIST_COUNT_DEF
) (
	input logic          clk,
	input logic          arst_n,
	dll_req_if.sink      req,
	dll_rsp_if.source    rsp
);
	localparam int IW = $clog2(NODE_COUNT);
	localparam int PW = $clog2(NODE_COUNT + 1);
	localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
	localparam int RW = 3 * PW;
	localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_NREAD, S_LREAD, S_LINK, S_LINK2,
		S_UNLINK, S_LWR, S_WALK, S_WALK_RD, S_DONE
	} state_t;

	state_t                        state_q;
	dll_pkg::func_t                op_q;
	logic [dll_pkg::LIST_ID_W-1:0] lid_q;
	logic [dll_pkg::NODE_ID_W-1:0] x_q;
	logic [dll_pkg::NODE_ID_W-1:0] r_q;
	logic [LW-1:0]                 l_q;
	logic [PW-1:0]                 p_q, n_q, cur_q, steps_q;
	logic [PW-1:0]                 size_q, head_q, tail_q;
	logic                          fail_q, have_q;

	logic                          out_valid_q, status_q, nonempty_q;
	logic [dll_pkg::COUNT_W-1:0]   count_q;
	logic [dll_pkg::NODE_ID_W-1:0] head_out_q, tail_out_q;

	// Table hookups
	dll_pkg::node_wr_t node_wr;
	logic              n_rd_en;
	logic [IW-1:0]     n_rd_idx, next_wa, prev_wa, link_idx;
	logic [PW-1:0]     next_rd, prev_rd, next_wd, prev_wd;
	logic [LW-1:0]     owner_rd;
	logic              lk_x, lk_r;
	logic              l_rd_en, l_wr_en;
	logic [LW-1:0]     l_rd_addr;
	logic [RW-1:0]     l_rd_data;

	// Decoded checks
	logic          x_ok, r_ok, lid_ok, owner_ok, done_walk, out_load;
	logic [IW-1:0] xi, ri;
	logic [PW-1:0] xptr, rptr;
	logic [PW-1:0] rd_size, rd_head, rd_tail;

	// Shared increment/decrement unit
	logic [PW-1:0] au_a, au_y;
	logic          au_dec;

	assign x_ok     = 32'(x_q) < NODE_COUNT;
	assign r_ok     = 32'(r_q) < NODE_COUNT;
	assign lid_ok   = 32'(lid_q) < LIST_COUNT;
	assign owner_ok = 32'(owner_rd) < LIST_COUNT;
	assign xi       = IW'(x_q);
	assign ri       = IW'(r_q);
	assign xptr     = PW'(x_q);
	assign rptr     = PW'(r_q);
	assign {rd_size, rd_head, rd_tail} = l_rd_data;
	assign done_walk = (cur_q == NIL) || (steps_q == PW'(NODE_COUNT));
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign au_a   = (state_q == S_WALK_RD) ? steps_q : size_q;
	assign au_dec = (state_q == S_UNLINK);
	assign au_y   = au_dec ? (au_a - PW'(1)) : (au_a + PW'(1));

	// Table control per step
	always_comb begin
		node_wr   = '0;
		n_rd_en   = 1'b0;
		n_rd_idx  = (op_q == dll_pkg::FN_REMOVE) ? xi : ri;
		next_wa   = xi;
		next_wd   = n_q;
		prev_wa   = xi;
		prev_wd   = p_q;
		link_idx  = xi;
		l_rd_en   = 1'b0;
		l_rd_addr = LW'(lid_q);
		l_wr_en   = 1'b0;
		unique case (state_q)
			S_CHECK: begin
				n_rd_en = 1'b1;
				l_rd_en = 1'b1;
			end
			S_NREAD: begin
				l_rd_en   = 1'b1;
				l_rd_addr = owner_rd;
			end
			S_LINK: begin
				node_wr.next_we  = 1'b1;
				node_wr.prev_we  = 1'b1;
				node_wr.link_set = 1'b1;
			end
			S_LINK2: begin
				node_wr.next_we = (p_q != NIL);
				next_wa         = IW'(p_q);
				next_wd         = xptr;
				node_wr.prev_we = (n_q != NIL);
				prev_wa         = IW'(n_q);
				prev_wd         = xptr;
				l_wr_en         = 1'b1;
			end
			S_UNLINK: begin
				node_wr.next_we  = (p_q != NIL);
				next_wa          = IW'(p_q);
				next_wd          = n_q;
				node_wr.prev_we  = (n_q != NIL);
				prev_wa          = IW'(n_q);
				prev_wd          = p_q;
				node_wr.link_clr = 1'b1;
			end
			S_LWR: begin
				l_wr_en = 1'b1;
			end
			S_WALK: begin
				n_rd_en          = !done_walk;
				n_rd_idx         = IW'(cur_q);
				link_idx         = IW'(cur_q);
				node_wr.link_clr = !done_walk;
			end
			S_IDLE, S_LREAD, S_WALK_RD, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	dll_node_tbl #(.NODE_COUNT(NODE_COUNT), .LIST_COUNT(LIST_COUNT)) u_node_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (node_wr),
		.rd_en    (n_rd_en),
		.rd_idx   (n_rd_idx),
		.next_rd  (next_rd),
		.prev_rd  (prev_rd),
		.owner_rd (owner_rd),
		.next_wa  (next_wa),
		.next_wd  (next_wd),
		.prev_wa  (prev_wa),
		.prev_wd  (prev_wd),
		.link_idx (link_idx),
		.owner_wd (l_q),
		.lk_a_idx (xi),
		.lk_b_idx (ri),
		.lk_a     (lk_x),
		.lk_b     (lk_r)
	);

	dll_list_tbl #(.NODE_COUNT(NODE_COUNT), .LIST_COUNT(LIST_COUNT)) u_list_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (l_rd_en),
		.rd_addr (l_rd_addr),
		.rd_data (l_rd_data),
		.wr_en   (l_wr_en),
		.wr_addr (l_q),
		.wr_data ({size_q, head_q, tail_q})
	);

	// Sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= dll_pkg::FN_CLEAN;
			fail_q      <= 1'b0;
			have_q      <= 1'b0;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.func;
						lid_q   <= req.list_id;
						x_q     <= req.node_id;
						r_q     <= req.ref_node_id;
						fail_q  <= 1'b0;
						have_q  <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					l_q <= LW'(lid_q);
					unique case (op_q)
						dll_pkg::FN_CLEAN, dll_pkg::FN_HEAD, dll_pkg::FN_TAIL: begin
							fail_q  <= !lid_ok;
							state_q <= lid_ok ? S_LREAD : S_DONE;
						end
						dll_pkg::FN_BEFORE, dll_pkg::FN_AFTER: begin
							fail_q  <= !(r_ok && lk_r);
							state_q <= (r_ok && lk_r) ? S_NREAD : S_DONE;
						end
						dll_pkg::FN_REMOVE: begin
							fail_q  <= !(x_ok && lk_x);
							state_q <= (x_ok && lk_x) ? S_NREAD : S_DONE;
						end
						default: begin
							fail_q  <= 1'b1;
							state_q <= S_DONE;
						end
					endcase
				end
				S_NREAD: begin
					l_q <= owner_rd;
					p_q <= (op_q == dll_pkg::FN_AFTER) ? rptr : prev_rd;
					n_q <= (op_q == dll_pkg::FN_BEFORE) ? rptr : next_rd;
					if (!owner_ok) begin
						fail_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_LREAD;
					end
				end
				S_LREAD: begin
					size_q <= rd_size;
					head_q <= rd_head;
					tail_q <= rd_tail;
					have_q <= 1'b1;
					if (op_q == dll_pkg::FN_CLEAN) begin
						cur_q   <= (rd_size != '0) ? rd_head : NIL;
						steps_q <= '0;
						state_q <= S_WALK;
					end else if (op_q == dll_pkg::FN_REMOVE) begin
						state_q <= S_UNLINK;
					end else if (!x_ok || lk_x) begin
						fail_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						if (op_q == dll_pkg::FN_HEAD) begin
							p_q <= NIL;
							n_q <= (rd_size != '0) ? rd_head : NIL;
						end else if (op_q == dll_pkg::FN_TAIL) begin
							p_q <= (rd_size != '0) ? rd_tail : NIL;
							n_q <= NIL;
						end
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (p_q == NIL) begin
						head_q <= xptr;
					end
					if (n_q == NIL) begin
						tail_q <= xptr;
					end
					if (32'(size_q) < NODE_COUNT) begin
						size_q <= au_y;
					end
					state_q <= S_LINK2;
				end
				S_LINK2: begin
					state_q <= S_DONE;
				end
				S_UNLINK: begin
					if (p_q == NIL) begin
						head_q <= n_q;
					end
					if (n_q == NIL) begin
						tail_q <= p_q;
					end
					if (size_q != '0) begin
						size_q <= au_y;
					end
					state_q <= S_LWR;
				end
				S_LWR: begin
					state_q <= S_DONE;
				end
				S_WALK: begin
					if (done_walk) begin
						size_q  <= '0;
						head_q  <= NIL;
						tail_q  <= NIL;
						state_q <= S_LWR;
					end else begin
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					cur_q   <= next_rd;
					steps_q <= au_y;
					state_q <= S_WALK;
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						status_q    <= fail_q;
						if (have_q && size_q != '0) begin
							count_q    <= dll_pkg::COUNT_W'(size_q);
							head_out_q <= dll_pkg::NODE_ID_W'(head_q);
							tail_out_q <= dll_pkg::NODE_ID_W'(tail_q);
							nonempty_q <= 1'b1;
						end else begin
							count_q    <= '0;
							head_out_q <= '0;
							tail_out_q <= '0;
							nonempty_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.list_count    = count_q;
	assign rsp.head_node     = head_out_q;
	assign rsp.tail_node     = tail_out_q;
	assign rsp.list_nonempty = nonempty_q;

	// Clean walk never runs past the pool size
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(steps_q) <= NODE_COUNT)
		else $error("clean walk step count beyond pool size");

	// A node being linked is never its own neighbor
	a_link_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK) |-> (p_q != xptr && n_q != xptr))
		else $error("link neighbor equals inserted node");

	// An empty report carries no head, tail or count
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !nonempty_q) |-> (count_q == '0 && head_out_q == '0 && tail_out_q == '0))
		else $error("empty list reported with nonzero fields");

	// A new response is only loaded from the done step
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside done step");

endmodule

// ===== tb/sv/doubly_linked_list_manager_tb.sv =====
// Self-checking testbench for the list manager: directed, pool-fill and random traffic.
`timescale 1ns / 1ps

module doubly_linked_list_manager_tb;

	localparam int NODES      = dll_pkg::NODE_COUNT_DEF;
	localparam int LISTS      = dll_pkg::LIST_COUNT_DEF;
	localparam int NIL        = NODES;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 150;
	localparam int CW         = dll_pkg::COUNT_W;
	localparam int NW         = dll_pkg::NODE_ID_W;
	localparam int LIW        = dll_pkg::LIST_ID_W;

	// Codes with no operation behind them
	localparam dll_pkg::func_t FN_SPARE_LO = 3'd6;
	localparam dll_pkg::func_t FN_SPARE_HI = 3'd7;

	typedef struct packed {
		dll_pkg::func_t         func;
		logic [LIW-1:0]         list_id;
		logic [NW-1:0]          node_id;
		logic [NW-1:0]          ref_node_id;
	} list_op_t;

	typedef struct packed {
		logic                   status;
		logic [CW-1:0]          list_count;
		logic [NW-1:0]          head_node;
		logic [NW-1:0]          tail_node;
		logic                   list_nonempty;
	} list_report_t;

	logic clk = 1'b0;
	logic arst_n;

	dll_req_if req_ch ();
	dll_rsp_if rsp_ch ();

	doubly_linked_list_manager u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the node pool and list tables
	logic [CW-1:0] pool_next   [NODES];
	logic [CW-1:0] pool_prev   [NODES];
	logic          pool_linked [NODES];
	int            pool_owner  [NODES];
	logic [CW-1:0] lst_head    [LISTS];
	logic [CW-1:0] lst_tail    [LISTS];
	logic [CW-1:0] lst_size    [LISTS];

	list_report_t pending_reports [$];

	int src_idle_pct;
	int snk_stall_pct;
	int error_count;
	int req_count;
	int rsp_count;
	int fail_count;
	int clean_count;
	int max_list_size;
	int max_clean_walk;
	int quiet_cycles;

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $realtime, what);
		error_count++;
	endtask

	// Predictor: node pool bookkeeping
	function automatic void clear_slot(input int x);
		pool_next[x]   = CW'(NIL);
		pool_prev[x]   = CW'(NIL);
		pool_linked[x] = 1'b0;
		pool_owner[x]  = 0;
	endfunction

	function automatic void reset_list_tables();
		for (int i = 0; i < NODES; i++)
			clear_slot(i);
		for (int i = 0; i < LISTS; i++) begin
			lst_head[i] = CW'(NIL);
			lst_tail[i] = CW'(NIL);
			lst_size[i] = '0;
		end
	endfunction

	// Splice x into list l between p and n; either neighbor may be NIL
	function automatic void splice_in(input int x, input int l, input int p, input int n);
		pool_prev[x]   = CW'(p);
		pool_next[x]   = CW'(n);
		pool_linked[x] = 1'b1;
		pool_owner[x]  = l;
		if (p < NODES) pool_next[p] = CW'(x);
		else lst_head[l] = CW'(x);
		if (n < NODES) pool_prev[n] = CW'(x);
		else lst_tail[l] = CW'(x);
		if (lst_size[l] < NODES) lst_size[l] = lst_size[l] + 1'b1;
		if (lst_size[l] > max_list_size) max_list_size = lst_size[l];
	endfunction

	function automatic list_report_t summarize_list(input bit fail, input bit have, input int l);
		list_report_t r;
		r = '0;
		r.status = fail;
		if (have && l < LISTS) begin
			r.list_count = lst_size[l];
			if (lst_size[l] != 0) begin
				r.head_node     = lst_head[l][NW-1:0];
				r.tail_node     = lst_tail[l][NW-1:0];
				r.list_nonempty = 1'b1;
			end
		end
		return r;
	endfunction

	// Apply one operation to the shadow tables and return the expected report
	function automatic list_report_t predict_list_op(input list_op_t op);
		int x, rf, l, p, n, cur, steps;
		list_report_t res;
		x  = op.node_id;
		rf = op.ref_node_id;
		case (op.func)
			dll_pkg::FN_CLEAN: begin
				l = op.list_id;
				cur = lst_head[l];
				steps = 0;
				while (steps < NODES && cur < NODES) begin
					n = pool_next[cur];
					clear_slot(cur);
					cur = n;
					steps++;
				end
				if (steps > max_clean_walk) max_clean_walk = steps;
				clean_count++;
				lst_head[l] = CW'(NIL);
				lst_tail[l] = CW'(NIL);
				lst_size[l] = '0;
				res = summarize_list(1'b0, 1'b1, l);
			end
			dll_pkg::FN_HEAD, dll_pkg::FN_TAIL: begin
				l = op.list_id;
				if (pool_linked[x]) begin
					res = summarize_list(1'b1, 1'b1, l);
				end else begin
					if (op.func == dll_pkg::FN_HEAD) splice_in(x, l, NIL, lst_head[l]);
					else splice_in(x, l, lst_tail[l], NIL);
					res = summarize_list(1'b0, 1'b1, l);
				end
			end
			dll_pkg::FN_BEFORE, dll_pkg::FN_AFTER: begin
				if (!pool_linked[rf]) begin
					res = summarize_list(1'b1, 1'b0, 0);
				end else begin
					l = pool_owner[rf];
					if (pool_linked[x]) begin
						res = summarize_list(1'b1, 1'b1, l);
					end else begin
						if (op.func == dll_pkg::FN_BEFORE) splice_in(x, l, pool_prev[rf], rf);
						else splice_in(x, l, rf, pool_next[rf]);
						res = summarize_list(1'b0, 1'b1, l);
					end
				end
			end
			dll_pkg::FN_REMOVE: begin
				if (!pool_linked[x]) begin
					res = summarize_list(1'b1, 1'b0, 0);
				end else begin
					l = pool_owner[x];
					p = pool_prev[x];
					n = pool_next[x];
					if (p < NODES) pool_next[p] = CW'(n);
					else lst_head[l] = CW'(n);
					if (n < NODES) pool_prev[n] = CW'(p);
					else lst_tail[l] = CW'(p);
					clear_slot(x);
					if (lst_size[l] > 0) lst_size[l] = lst_size[l] - 1'b1;
					res = summarize_list(1'b0, 1'b1, l);
				end
			end
			default: res = summarize_list(1'b1, 1'b0, 0);
		endcase
		if (res.status) fail_count++;
		return res;
	endfunction

	// Random pick among linked (or unlinked) nodes; -1 when there is none
	function automatic int pick_node(input bit want_linked);
		int cnt, k;
		cnt = 0;
		for (int i = 0; i < NODES; i++)
			if (pool_linked[i] == want_linked) cnt++;
		if (cnt == 0) return -1;
		k = $urandom_range(0, cnt - 1);
		for (int i = 0; i < NODES; i++) begin
			if (pool_linked[i] == want_linked) begin
				if (k == 0) return i;
				k--;
			end
		end
		return -1;
	endfunction

	function automatic list_op_t mk_op(input dll_pkg::func_t f, input int l, input int n,
		input int r);
		list_op_t op;
		op.func        = f;
		op.list_id     = l[LIW-1:0];
		op.node_id     = n[NW-1:0];
		op.ref_node_id = r[NW-1:0];
		return op;
	endfunction

	// Mostly well-formed operations on the current pool, some broken ones and noise
	function automatic list_op_t make_random_op();
		list_op_t op;
		int roll, nlinked, n, thr;
		op = mk_op(dll_pkg::FN_CLEAN, $urandom, $urandom, $urandom);
		nlinked = 0;
		for (int i = 0; i < NODES; i++)
			if (pool_linked[i]) nlinked++;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			op.func = dll_pkg::func_t'($urandom_range(0, 7));
		end else if (roll < 12) begin
			op.func = dll_pkg::FN_CLEAN;
		end else if (roll < 18) begin
			case ($urandom_range(0, 2))
				0: begin
					op.func = $urandom_range(0, 1) ? dll_pkg::FN_HEAD : dll_pkg::FN_TAIL;
					n = pick_node(1'b1);
					if (n >= 0) op.node_id = n[NW-1:0];
				end
				1: begin
					op.func = dll_pkg::FN_REMOVE;
					n = pick_node(1'b0);
					if (n >= 0) op.node_id = n[NW-1:0];
				end
				default: begin
					op.func = $urandom_range(0, 1) ? dll_pkg::FN_BEFORE : dll_pkg::FN_AFTER;
					n = pick_node(1'b0);
					if (n >= 0) op.ref_node_id = n[NW-1:0];
				end
			endcase
		end else begin
			// removes grow more likely as the pool fills up
			thr = 15 + nlinked;
			roll = $urandom_range(0, 99);
			if (roll < thr) begin
				op.func = dll_pkg::FN_REMOVE;
				n = pick_node(1'b1);
				if (n >= 0) op.node_id = n[NW-1:0];
			end else begin
				n = pick_node(1'b0);
				if (n >= 0) op.node_id = n[NW-1:0];
				if (roll < thr + (100 - thr) / 2) begin
					op.func = $urandom_range(0, 1) ? dll_pkg::FN_HEAD : dll_pkg::FN_TAIL;
				end else begin
					op.func = $urandom_range(0, 1) ? dll_pkg::FN_BEFORE : dll_pkg::FN_AFTER;
					n = pick_node(1'b1);
					if (n >= 0) op.ref_node_id = n[NW-1:0];
				end
			end
		end
		return op;
	endfunction

	// Send one request transaction; called and returns at a falling edge, valid left high
	task automatic send_list_op(input list_op_t op);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.func        <= op.func;
		req_ch.list_id     <= op.list_id;
		req_ch.node_id     <= op.node_id;
		req_ch.ref_node_id <= op.ref_node_id;
		do @(posedge clk); while (!req_ch.ready);
		pending_reports.push_back(predict_list_op(op));
		req_count++;
		@(negedge clk);
	endtask

	// Hold off the sender until every outstanding report has come back
	task automatic wait_all_reported();
		req_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
	endtask

	// Receiver stalls
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

	// Response checker
	always @(posedge clk) begin
		list_report_t got, want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status        = rsp_ch.status;
			got.list_count    = rsp_ch.list_count;
			got.head_node     = rsp_ch.head_node;
			got.tail_node     = rsp_ch.tail_node;
			got.list_nonempty = rsp_ch.list_nonempty;
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("response %0d with no request outstanding", rsp_count));
			end else begin
				want = pending_reports.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("rsp %0d status: got %0b want %0b",
						rsp_count, got.status, want.status));
				if (got.list_count !== want.list_count)
					report_mismatch($sformatf("rsp %0d list_count: got %0d want %0d",
						rsp_count, got.list_count, want.list_count));
				if (got.head_node !== want.head_node)
					report_mismatch($sformatf("rsp %0d head_node: got %0d want %0d",
						rsp_count, got.head_node, want.head_node));
				if (got.tail_node !== want.tail_node)
					report_mismatch($sformatf("rsp %0d tail_node: got %0d want %0d",
						rsp_count, got.tail_node, want.tail_node));
				if (got.list_nonempty !== want.list_nonempty)
					report_mismatch($sformatf("rsp %0d list_nonempty: got %0b want %0b",
						rsp_count, got.list_nonempty, want.list_nonempty));
			end
			rsp_count++;
		end
	end

	// Watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: %0d cycles without a transaction", quiet_cycles);
			$display("doubly_linked_list_manager_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Extremes of every field and each failure case
	task automatic test_directed();
		send_list_op(mk_op(dll_pkg::FN_CLEAN, 0, 0, 0));     // clean of an empty list
		send_list_op(mk_op(dll_pkg::FN_REMOVE, 0, 5, 0));    // remove of an unlinked node
		send_list_op(mk_op(dll_pkg::FN_BEFORE, 1, 8, 7));    // unlinked reference
		send_list_op(mk_op(dll_pkg::FN_HEAD, 0, 0, 0));
		send_list_op(mk_op(dll_pkg::FN_TAIL, 3, 63, 63));
		send_list_op(mk_op(dll_pkg::FN_HEAD, 0, 1, 0));
		send_list_op(mk_op(dll_pkg::FN_AFTER, 2, 2, 0));     // after the tail
		send_list_op(mk_op(dll_pkg::FN_BEFORE, 0, 3, 1));    // before the head
		send_list_op(mk_op(dll_pkg::FN_BEFORE, 3, 4, 0));    // in the middle
		send_list_op(mk_op(dll_pkg::FN_AFTER, 0, 62, 63));
		send_list_op(mk_op(dll_pkg::FN_HEAD, 1, 0, 0));      // node already linked
		send_list_op(mk_op(dll_pkg::FN_AFTER, 0, 0, 0));     // reference is the node itself
		send_list_op(mk_op(dll_pkg::FN_BEFORE, 0, 2, 63));   // linked node, other list
		send_list_op(mk_op(FN_SPARE_LO, 0, 0, 0));           // unused codes
		send_list_op(mk_op(FN_SPARE_HI, 3, 63, 63));
		send_list_op(mk_op(dll_pkg::FN_REMOVE, 0, 4, 0));    // middle node
		send_list_op(mk_op(dll_pkg::FN_REMOVE, 0, 3, 0));    // head node
		send_list_op(mk_op(dll_pkg::FN_REMOVE, 0, 2, 0));    // tail node
		send_list_op(mk_op(dll_pkg::FN_TAIL, 2, 42, 0));
		send_list_op(mk_op(dll_pkg::FN_REMOVE, 1, 42, 0));   // last node of a list
		send_list_op(mk_op(dll_pkg::FN_CLEAN, 0, 0, 0));
		send_list_op(mk_op(dll_pkg::FN_CLEAN, 3, 0, 0));
		send_list_op(mk_op(dll_pkg::FN_REMOVE, 0, 0, 0));    // cleaned node is unlinked
		send_list_op(mk_op(dll_pkg::FN_HEAD, 1, 21, 63));
	endtask

	// Every node of the pool into one list, some churn, then one long clean
	task automatic test_fill_one_list();
		int order [NODES];
		int j, t, r;
		dll_pkg::func_t f;
		for (int l = 0; l < LISTS; l++)
			send_list_op(mk_op(dll_pkg::FN_CLEAN, l, $urandom, $urandom));
		for (int i = 0; i < NODES; i++)
			order[i] = i;
		for (int i = NODES - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < NODES + 24; i++) begin
			if (i >= NODES && i < NODES + 12) begin
				r = pick_node(1'b1);
				send_list_op(mk_op(dll_pkg::FN_REMOVE, $urandom, r, $urandom));
			end else begin
				t = (i < NODES) ? order[i] : pick_node(1'b0);
				r = pick_node(1'b1);
				if (r < 0) f = dll_pkg::FN_HEAD;
				else f = dll_pkg::func_t'($urandom_range(dll_pkg::FN_HEAD, dll_pkg::FN_AFTER));
				if (r < 0) r = $urandom;
				send_list_op(mk_op(f, 2, t, r));
			end
		end
		send_list_op(mk_op(dll_pkg::FN_CLEAN, 2, $urandom, $urandom));
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++)
			send_list_op(make_random_op());
	endtask

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.func        = dll_pkg::FN_CLEAN;
		req_ch.list_id     = '0;
		req_ch.node_id     = '0;
		req_ch.ref_node_id = '0;
		error_count        = 0;
		req_count          = 0;
		rsp_count          = 0;
		fail_count         = 0;
		clean_count        = 0;
		max_list_size      = 0;
		max_clean_walk     = 0;
		src_idle_pct       = 32;
		snk_stall_pct      = 61;
		reset_list_tables();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_fill_one_list();
		test_random_mix(545);
		wait_all_reported();

		src_idle_pct  = 61;
		snk_stall_pct = 32;
		test_random_mix(545);

		src_idle_pct  = 0;
		snk_stall_pct = 0;
		test_random_mix(545);

		// drain and let the block settle
		wait_all_reported();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_reports.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", pending_reports.size()));

		$display("Ran %0d list requests (%0d failing, %0d cleans) and checked %0d responses",
			req_count, fail_count, clean_count, rsp_count);
		$display("under three stall profiles; largest list %0d nodes, longest clean walk %0d nodes",
			max_list_size, max_clean_walk);
		if (error_count == 0) begin
			$display("doubly_linked_list_manager_tb OK");
		end else begin
			$display("doubly_linked_list_manager_tb NOT OK");
		end
		$finish;
	end

endmodule
